>>> rtl/assert_macros.svh
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, checked on clk, off while rst_n is low
`define GIC_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, checked on clk, off while rst_n is low
`define GIC_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> rtl/gic_pkg.sv
package gic_pkg;

  localparam int NUM_KEYS = 10;
  localparam int IN_AXES  = 4;
  localparam int ADC_W    = 12;
  localparam int AXIS_W   = 8;
  localparam int IN_W     = 64;
  localparam int OUT_W    = 56;
  localparam int CFG_AW   = 5;
  localparam int CFG_DW   = 32;

  localparam logic [AXIS_W-1:0] AXIS_CENTER = 8'd128;

  localparam logic [2:0] REG_CENTER_LX = 3'd0;
  localparam logic [2:0] REG_CENTER_LY = 3'd1;
  localparam logic [2:0] REG_CENTER_RX = 3'd2;
  localparam logic [2:0] REG_CENTER_RY = 3'd3;
  localparam logic [2:0] REG_COEF_B0   = 3'd4;
  localparam logic [2:0] REG_COEF_B1   = 3'd5;
  localparam logic [2:0] REG_COEF_A1   = 3'd6;
  localparam logic [2:0] REG_DEADZONE  = 3'd7;

  localparam int KEY_X     = 0;
  localparam int KEY_Y     = 1;
  localparam int KEY_UP    = 2;
  localparam int KEY_DOWN  = 3;
  localparam int KEY_L1    = 4;
  localparam int KEY_R1    = 5;
  localparam int KEY_B     = 6;
  localparam int KEY_LEFT  = 7;
  localparam int KEY_RIGHT = 8;
  localparam int KEY_A     = 9;

  localparam logic [3:0] HAT_N    = 4'd0;
  localparam logic [3:0] HAT_NE   = 4'd1;
  localparam logic [3:0] HAT_E    = 4'd2;
  localparam logic [3:0] HAT_SE   = 4'd3;
  localparam logic [3:0] HAT_S    = 4'd4;
  localparam logic [3:0] HAT_SW   = 4'd5;
  localparam logic [3:0] HAT_W    = 4'd6;
  localparam logic [3:0] HAT_NW   = 4'd7;
  localparam logic [3:0] HAT_NONE = 4'd8;

  localparam logic [ADC_W-1:0] CENTER_RST   = 12'd2048;
  localparam logic [15:0]      COEF_B_RST   = 16'd8834;
  localparam logic [15:0]      COEF_A1_RST  = 16'hA282;
  localparam logic [14:0]      DEADZONE_RST = 15'd2048;

  typedef logic [NUM_KEYS-1:0] keys_t;
  typedef logic [AXIS_W-1:0]   axis_t;
  typedef logic [ADC_W-1:0]    adc_t;

  typedef struct packed {
    logic [15:0] b0;
    logic [15:0] b1;
    logic [15:0] a1;
    logic [14:0] deadzone;
  } filt_cfg_t;

  typedef struct packed {
    logic adv;
    logic load_a;
    logic load_d;
  } pipe_ctl_t;

endpackage

>>> rtl/gic_debounce.sv
module gic_debounce #(
  parameter int DEBOUNCE_TICKS = 20
) (
  input  logic              clk,
  input  logic              rst_n,
  input  gic_pkg::pipe_ctl_t ctl,
  input  gic_pkg::keys_t    raw_keys,
  output gic_pkg::keys_t    keys
);
  import gic_pkg::*;

  localparam logic [8:0] TICKS = 9'(DEBOUNCE_TICKS);

  keys_t      deb_r;
  keys_t      deb_nxt;
  logic [7:0] cnt_r   [NUM_KEYS];
  logic [7:0] cnt_nxt [NUM_KEYS];

  always_comb begin
    logic [8:0] inc;
    inc = '0;
    deb_nxt = deb_r;
    for (int k = 0; k < NUM_KEYS; k++) begin
      inc = {1'b0, cnt_r[k]} + 9'd1;
      cnt_nxt[k] = '0;
      if (raw_keys[k] != deb_r[k]) begin
        if (inc >= TICKS) begin
          deb_nxt[k] = ~deb_r[k];
        end else begin
          cnt_nxt[k] = inc[7:0];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      deb_r <= '0;
      for (int k = 0; k < NUM_KEYS; k++) cnt_r[k] <= '0;
    end else if (ctl.load_a) begin
      deb_r <= deb_nxt;
      for (int k = 0; k < NUM_KEYS; k++) cnt_r[k] <= cnt_nxt[k];
    end
  end

  assign keys = deb_r;

endmodule

>>> rtl/gic_axis_lane.sv
module gic_axis_lane (
  input  logic                clk,
  input  logic                rst_n,
  input  gic_pkg::pipe_ctl_t  ctl,
  input  gic_pkg::adc_t       adc,
  input  gic_pkg::adc_t       center,
  input  gic_pkg::filt_cfg_t  coef,
  output gic_pkg::axis_t      axis
);
  import gic_pkg::*;

  logic signed [12:0] off;
  logic signed [16:0] scaled;
  logic signed [15:0] x_nxt;
  logic signed [15:0] x_r, xp_r;
  logic signed [31:0] m0_r, m1_r;
  logic signed [32:0] ff_r;
  logic signed [31:0] fb_prod;
  logic signed [33:0] acc;
  logic signed [18:0] acc_sh;
  logic signed [15:0] y_nxt;
  logic signed [15:0] y_r;
  axis_t              a_raw;
  axis_t              gap;

  assign off    = $signed({1'b0, adc}) - $signed({1'b0, center});
  assign scaled = $signed({off, 4'b0000});

  always_comb begin
    if (scaled[16] != scaled[15]) begin
      x_nxt = scaled[16] ? 16'sh8000 : 16'sh7fff;
    end else begin
      x_nxt = scaled[15:0];
    end
  end

  assign fb_prod = $signed(coef.a1) * y_r;
  assign acc     = $signed({ff_r[32], ff_r}) + $signed({{2{fb_prod[31]}}, fb_prod});
  assign acc_sh  = acc[33:15];

  always_comb begin
    if ((acc_sh[18:15] != 4'b0000) && (acc_sh[18:15] != 4'b1111)) begin
      y_nxt = acc_sh[18] ? 16'sh8000 : 16'sh7fff;
    end else begin
      y_nxt = acc_sh[15:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      x_r  <= '0;
      xp_r <= '0;
      y_r  <= '0;
    end else begin
      if (ctl.load_a) begin
        x_r  <= x_nxt;
        xp_r <= x_r;
      end
      if (ctl.load_d) begin
        y_r <= y_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.adv) begin
      m0_r <= $signed(coef.b0) * x_r;
      m1_r <= $signed(coef.b1) * xp_r;
      ff_r <= $signed({m0_r[31], m0_r}) + $signed({m1_r[31], m1_r});
    end
  end

  assign a_raw = {~y_r[15], y_r[14:8]};
  assign gap   = a_raw[7] ? {1'b0, a_raw[6:0]} : AXIS_CENTER - a_raw;
  assign axis  = (gap < {1'b0, coef.deadzone[14:8]}) ? AXIS_CENTER : a_raw;

endmodule

>>> rtl/gic_merge.sv
module gic_merge (
  input  gic_pkg::keys_t           keys,
  input  gic_pkg::axis_t           axis [gic_pkg::IN_AXES],
  output logic [gic_pkg::OUT_W-1:0] data
);
  import gic_pkg::*;

  logic [5:0] btn_low;
  logic [3:0] dir;
  logic [3:0] hat;

  assign btn_low = {keys[KEY_R1], keys[KEY_L1], keys[KEY_Y],
                    keys[KEY_B], keys[KEY_A], keys[KEY_X]};
  assign dir     = {keys[KEY_LEFT], keys[KEY_DOWN], keys[KEY_RIGHT], keys[KEY_UP]};

  always_comb begin
    unique case (dir)
      4'b0001: hat = HAT_N;
      4'b0011: hat = HAT_NE;
      4'b0010: hat = HAT_E;
      4'b0110: hat = HAT_SE;
      4'b0100: hat = HAT_S;
      4'b1100: hat = HAT_SW;
      4'b1000: hat = HAT_W;
      4'b1001: hat = HAT_NW;
      default: hat = HAT_NONE;
    endcase
  end

  assign data = {3'b000, keys, axis[3], axis[2], axis[1], axis[0],
                 hat, keys[KEY_RIGHT], btn_low};

endmodule

>>> rtl/gamepad_input_conditioner.sv
// Gamepad input conditioner: one input item per 1 ms tick carries ten raw key bits and four
// 12-bit stick samples; one result item comes back for each. Keys are debounced one by one,
// sticks are centered, scaled to Q15 and run through a first-order Q15 filter, one lane per
// axis up to NUM_AXES, further axes held at center. An item is accepted every cycle while
// the output side keeps up; the whole pipe holds while it stalls. Each item passes through
// registers in order: the scale register loads at the accepting edge, then the two products,
// their sum, the feedback multiply-add, which is combinational into its register, and the
// output register. Registers on the cfg_ port: center_lx/ly/rx/ry at 0x00..0x0C, coef_b0
// 0x10, coef_b1 0x14, coef_a1 0x18, deadzone 0x1C; write them only while no item is in flight.
module gamepad_input_conditioner #(
  parameter int DEBOUNCE_TICKS = 20,
  parameter int NUM_AXES       = 4
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_tvalid,
  output logic                         in_tready,
  // raw_keys[9:0], adc_lx[21:10], adc_ly[33:22], adc_rx[45:34], adc_ry[57:46], zero pad
  input  logic [gic_pkg::IN_W-1:0]     in_tdata,
  output logic                         out_tvalid,
  input  logic                         out_tready,
  // buttons_low[5:0], buttons_high[6], hat[10:7], axis_lx[18:11], axis_ly[26:19],
  // axis_rx[34:27], axis_ry[42:35], key_states[52:43], zero pad
  output logic [gic_pkg::OUT_W-1:0]    out_tdata,
  input  logic                         cfg_psel,
  input  logic                         cfg_penable,
  input  logic                         cfg_pwrite,
  input  logic [gic_pkg::CFG_AW-1:0]   cfg_paddr,
  input  logic [gic_pkg::CFG_DW-1:0]   cfg_pwdata,
  output logic [gic_pkg::CFG_DW-1:0]   cfg_prdata,
  output logic                         cfg_pready
);
  import gic_pkg::*;
  `include "assert_macros.svh"

  localparam int LANES = (NUM_AXES < IN_AXES) ? NUM_AXES : IN_AXES;

  adc_t       center_r [IN_AXES];
  filt_cfg_t  coef_r;
  logic       cfg_wr;
  logic [2:0] cfg_idx;

  logic [3:0]       v_r;
  keys_t            kb_r, kc_r, kd_r;
  keys_t            ka;
  logic             out_valid_r;
  logic [OUT_W-1:0] out_data_r;
  logic [OUT_W-1:0] merged;
  pipe_ctl_t        ctl;
  axis_t            axis [IN_AXES];
  logic             adv;

  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite;
  assign cfg_idx    = cfg_paddr[4:2];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < IN_AXES; i++) center_r[i] <= CENTER_RST;
      coef_r.b0       <= COEF_B_RST;
      coef_r.b1       <= COEF_B_RST;
      coef_r.a1       <= COEF_A1_RST;
      coef_r.deadzone <= DEADZONE_RST;
    end else if (cfg_wr) begin
      unique case (cfg_idx)
        REG_CENTER_LX: center_r[0] <= cfg_pwdata[ADC_W-1:0];
        REG_CENTER_LY: center_r[1] <= cfg_pwdata[ADC_W-1:0];
        REG_CENTER_RX: center_r[2] <= cfg_pwdata[ADC_W-1:0];
        REG_CENTER_RY: center_r[3] <= cfg_pwdata[ADC_W-1:0];
        REG_COEF_B0:   coef_r.b0 <= cfg_pwdata[15:0];
        REG_COEF_B1:   coef_r.b1 <= cfg_pwdata[15:0];
        REG_COEF_A1:   coef_r.a1 <= cfg_pwdata[15:0];
        REG_DEADZONE:  coef_r.deadzone <= cfg_pwdata[14:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (cfg_idx)
      REG_CENTER_LX: cfg_prdata = {20'd0, center_r[0]};
      REG_CENTER_LY: cfg_prdata = {20'd0, center_r[1]};
      REG_CENTER_RX: cfg_prdata = {20'd0, center_r[2]};
      REG_CENTER_RY: cfg_prdata = {20'd0, center_r[3]};
      REG_COEF_B0:   cfg_prdata = {{16{coef_r.b0[15]}}, coef_r.b0};
      REG_COEF_B1:   cfg_prdata = {{16{coef_r.b1[15]}}, coef_r.b1};
      REG_COEF_A1:   cfg_prdata = {{16{coef_r.a1[15]}}, coef_r.a1};
      REG_DEADZONE:  cfg_prdata = {17'd0, coef_r.deadzone};
      default:       cfg_prdata = '0;
    endcase
  end

  // advance the whole pipe whenever the output register is free or drains
  assign adv        = !out_valid_r || out_tready;
  assign in_tready  = adv;
  assign ctl.adv    = adv;
  assign ctl.load_a = in_tvalid && adv;
  assign ctl.load_d = v_r[2] && adv;

  gic_debounce #(
    .DEBOUNCE_TICKS (DEBOUNCE_TICKS)
  ) u_debounce (
    .clk      (clk),
    .rst_n    (rst_n),
    .ctl      (ctl),
    .raw_keys (in_tdata[NUM_KEYS-1:0]),
    .keys     (ka)
  );

  for (genvar i = 0; i < IN_AXES; i++) begin : g_axis
    if (i < LANES) begin : g_lane
      gic_axis_lane u_lane (
        .clk    (clk),
        .rst_n  (rst_n),
        .ctl    (ctl),
        .adc    (in_tdata[NUM_KEYS + ADC_W*i +: ADC_W]),
        .center (center_r[i]),
        .coef   (coef_r),
        .axis   (axis[i])
      );
    end else begin : g_fixed
      assign axis[i] = AXIS_CENTER;
    end
  end

  gic_merge u_merge (
    .keys (kd_r),
    .axis (axis),
    .data (merged)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r         <= '0;
      out_valid_r <= 1'b0;
    end else if (adv) begin
      v_r         <= {v_r[2:0], in_tvalid};
      out_valid_r <= v_r[3];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      kb_r       <= ka;
      kc_r       <= kb_r;
      kd_r       <= kc_r;
      out_data_r <= merged;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  logic [3:0] out_hat;
  keys_t      out_keys;
  assign out_hat  = out_data_r[10:7];
  assign out_keys = out_data_r[52:43];

  `GIC_ASSERT_NXT(a_stall_holds_pipe, out_valid_r && !out_tready, $stable(v_r),
                  "pipeline moved while output stalled")
  `GIC_ASSERT_IMP(a_out_from_last_stage, $rose(out_valid_r), $past(v_r[3]),
                  "output valid without an item in the last stage")
  `GIC_ASSERT_IMP(a_hat_no_conflict, out_valid_r && (out_hat != HAT_NONE),
                  !(out_keys[KEY_UP] && out_keys[KEY_DOWN]) &&
                  !(out_keys[KEY_LEFT] && out_keys[KEY_RIGHT]),
                  "hat direction from conflicting keys")

endmodule
